// File: rtl/pppfs_pkg.sv
// ----------------------------------------------------------------------------
// pppfs_pkg: shared types and constants of the PPP frame stuffer
// Holds the line codes, the register map, the item descriptor passed from the
// front end to the back end, and the CRC-16/MODBUS byte table.
// ----------------------------------------------------------------------------
package pppfs_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] PAD_BYTE   = 8'h00;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] ADDR_RESET  = 8'hFF;
	localparam logic [7:0] CTRL_RESET  = 8'h03;
	localparam logic [7:0] PROTO_RESET = 8'h21;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		REG_ADDRESS  = 2'd0,
		REG_CONTROL  = 2'd1,
		REG_PROTOCOL = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [7:0] address;
		logic [7:0] control;
		logic [7:0] protocol;
	} cfg_t;

	typedef struct packed {
		logic       hdr;
		logic       esc;
		logic       eop;
		logic [7:0] data;
	} item_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_H0,
		PH_H1,
		PH_H2,
		PH_H3,
		PH_H4,
		PH_ESC,
		PH_DATA,
		PH_FCS_LO,
		PH_FCS_HI,
		PH_CLOSE
	} phase_t;

	typedef logic [15:0] crc_table_t [256];

	function automatic crc_table_t crc_build_table();
		crc_table_t  t;
		logic [15:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 16'(i);
			for (int k = 0; k < 8; k++) begin
				if (c[0]) begin
					c = (c >> 1) ^ CRC_POLY;
				end else begin
					c = c >> 1;
				end
			end
			t[i] = c;
		end
		return t;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_build_table();

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] idx;
		idx = crc[7:0] ^ b;
		return {8'h00, crc[15:8]} ^ CRC_TABLE[idx];
	endfunction

endpackage

// File: rtl/pppfs_front.sv
// ----------------------------------------------------------------------------
// pppfs_front: request intake and classification
// Takes payload requests, tracks whether a frame is open, and turns each
// request into a descriptor that tells the back end what to emit.
// ----------------------------------------------------------------------------
module pppfs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       payload_byte,
	input  logic             end_of_packet,
	input  logic             q_full,
	output logic             q_wr,
	output pppfs_pkg::item_t q_item
);

	logic open_q;
	logic esc;

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		esc = payload_byte inside {pppfs_pkg::FLAG_BYTE, pppfs_pkg::ESC_BYTE,
			[8'h00 : pppfs_pkg::CTRL_LIMIT - 8'h01]};
		q_item.hdr  = !open_q;
		q_item.esc  = esc;
		q_item.eop  = end_of_packet;
		q_item.data = esc ? (payload_byte ^ pppfs_pkg::ESC_XOR) : payload_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (q_wr) begin
			open_q <= !end_of_packet;
		end
	end

	a_close_on_eop: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && end_of_packet) |=> !open_q)
		else $error("frame still open after its last request");

	a_open_on_body: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && !end_of_packet) |=> open_q)
		else $error("frame not open after a body request");

	a_hdr_only_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wr && q_item.hdr) |-> !$past(open_q) || $past(q_wr && end_of_packet))
		else $error("header requested inside an open frame");

endmodule

// File: rtl/pppfs_queue.sv
// ----------------------------------------------------------------------------
// pppfs_queue: descriptor queue between front end and back end
// A short register queue that lets the intake and the byte sequencer stall
// independently of each other.
// ----------------------------------------------------------------------------
module pppfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  pppfs_pkg::item_t wr_item,
	output logic             full,
	input  logic             rd,
	output logic             valid,
	output pppfs_pkg::item_t rd_item
);

	pppfs_pkg::item_t                  mem_q [pppfs_pkg::QUEUE_DEPTH];
	logic [pppfs_pkg::QUEUE_AW-1:0]    wptr_q;
	logic [pppfs_pkg::QUEUE_AW-1:0]    rptr_q;
	logic [pppfs_pkg::QUEUE_AW:0]      count_q;

	assign full    = count_q == (pppfs_pkg::QUEUE_AW+1)'(pppfs_pkg::QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (pppfs_pkg::QUEUE_AW+1)'(pppfs_pkg::QUEUE_DEPTH))
		else $error("descriptor queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> valid)
		else $error("descriptor queue read while empty");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("descriptor queue written while full");

endmodule

// File: rtl/pppfs_back.sv
// ----------------------------------------------------------------------------
// pppfs_back: byte sequencer, FCS and output register
// Walks each descriptor through header, escape, data, FCS and closing flag,
// one line byte per cycle unless stalled, and keeps the running CRC-16/MODBUS.
// ----------------------------------------------------------------------------
module pppfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pppfs_pkg::cfg_t   cfg,
	input  logic              q_valid,
	input  pppfs_pkg::item_t  q_item,
	output logic              q_rd,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        line_byte,
	output logic              last_of_run,
	output logic              frame_closed
);

	pppfs_pkg::phase_t phase_q;
	pppfs_pkg::phase_t cur;
	pppfs_pkg::phase_t nxt;
	pppfs_pkg::phase_t body;
	logic [15:0]       crc_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_closed_q;
	logic              emit;
	logic              done;
	logic              crc_en;
	logic              closed;
	logic [7:0]        byte_val;

	assign emit         = q_valid && (!out_valid_q || pop);
	assign q_rd         = emit && done;
	assign empty        = !out_valid_q;
	assign line_byte    = out_byte_q;
	assign last_of_run  = out_last_q;
	assign frame_closed = out_closed_q;

	always_comb begin
		body = q_item.esc ? pppfs_pkg::PH_ESC : pppfs_pkg::PH_DATA;
		cur  = (phase_q == pppfs_pkg::PH_START) ?
			(q_item.hdr ? pppfs_pkg::PH_H0 : body) : phase_q;
		nxt      = pppfs_pkg::PH_START;
		done     = 1'b0;
		crc_en   = 1'b1;
		closed   = 1'b0;
		byte_val = pppfs_pkg::FLAG_BYTE;
		case (cur)
			pppfs_pkg::PH_H0: begin
				byte_val = pppfs_pkg::FLAG_BYTE;
				nxt      = pppfs_pkg::PH_H1;
			end
			pppfs_pkg::PH_H1: begin
				byte_val = cfg.address;
				nxt      = pppfs_pkg::PH_H2;
			end
			pppfs_pkg::PH_H2: begin
				byte_val = cfg.control;
				nxt      = pppfs_pkg::PH_H3;
			end
			pppfs_pkg::PH_H3: begin
				byte_val = pppfs_pkg::PAD_BYTE;
				nxt      = pppfs_pkg::PH_H4;
			end
			pppfs_pkg::PH_H4: begin
				byte_val = cfg.protocol;
				nxt      = body;
			end
			pppfs_pkg::PH_ESC: begin
				byte_val = pppfs_pkg::ESC_BYTE;
				nxt      = pppfs_pkg::PH_DATA;
			end
			pppfs_pkg::PH_DATA: begin
				byte_val = q_item.data;
				nxt      = pppfs_pkg::PH_FCS_LO;
				done     = !q_item.eop;
			end
			pppfs_pkg::PH_FCS_LO: begin
				byte_val = crc_q[7:0];
				crc_en   = 1'b0;
				nxt      = pppfs_pkg::PH_FCS_HI;
			end
			pppfs_pkg::PH_FCS_HI: begin
				byte_val = crc_q[15:8];
				crc_en   = 1'b0;
				nxt      = pppfs_pkg::PH_CLOSE;
			end
			pppfs_pkg::PH_CLOSE: begin
				byte_val = pppfs_pkg::FLAG_BYTE;
				crc_en   = 1'b0;
				closed   = 1'b1;
				done     = 1'b1;
			end
			default: begin
				done   = 1'b1;
				crc_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pppfs_pkg::PH_START;
			crc_q       <= pppfs_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q     <= done ? pppfs_pkg::PH_START : nxt;
				out_valid_q <= 1'b1;
				if (closed) begin
					crc_q <= pppfs_pkg::CRC_INIT;
				end else if (crc_en) begin
					crc_q <= pppfs_pkg::crc_update(crc_q, byte_val);
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= byte_val;
			out_last_q   <= done;
			out_closed_q <= closed;
		end
	end

	a_crc_seeded_at_header: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cur == pppfs_pkg::PH_H0) |-> crc_q == pppfs_pkg::CRC_INIT)
		else $error("FCS not seeded at the opening flag");

	a_crc_reset_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cur == pppfs_pkg::PH_CLOSE) |=> crc_q == pppfs_pkg::CRC_INIT)
		else $error("FCS not reset after the closing flag");

	a_restart_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> phase_q == pppfs_pkg::PH_START && out_valid_q && out_last_q)
		else $error("sequencer did not finish the request cleanly");

endmodule

// File: rtl/ppp_frame_stuffer_crc16.sv
// ----------------------------------------------------------------------------
// ppp_frame_stuffer_crc16: PPP-style framer with byte stuffing and FCS-16
// Emits the frame header, the stuffed payload, the CRC-16/MODBUS FCS and the
// closing flag for a stream of payload bytes.
//
//   channel   handshake        payload
//   input     push / full      payload_byte, end_of_packet
//   result    pop / empty      line_byte, last_of_run, frame_closed
//   config    cfg_we           cfg_index, cfg_wdata
//
// One line byte leaves per cycle, unless the line side stalls, through a single
// output register; a request produces one line byte for a plain byte, two for
// an escaped byte, plus five for a frame header and three for FCS and flag.
// The descriptor queue holds four requests, so intake runs ahead of the line.
// Reset clears the queue, the frame state and the FCS; it loads the header
// registers with their default values. Both sides may stall at any cycle.
// ----------------------------------------------------------------------------
module ppp_frame_stuffer_crc16 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] payload_byte,
	input  logic       end_of_packet,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] line_byte,
	output logic       last_of_run,
	output logic       frame_closed,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	pppfs_pkg::cfg_t  cfg_q;
	pppfs_pkg::item_t wr_item;
	pppfs_pkg::item_t rd_item;
	logic             q_wr;
	logic             q_rd;
	logic             q_full;
	logic             q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address  <= pppfs_pkg::ADDR_RESET;
			cfg_q.control  <= pppfs_pkg::CTRL_RESET;
			cfg_q.protocol <= pppfs_pkg::PROTO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pppfs_pkg::REG_ADDRESS:  cfg_q.address  <= cfg_wdata;
				pppfs_pkg::REG_CONTROL:  cfg_q.control  <= cfg_wdata;
				pppfs_pkg::REG_PROTOCOL: cfg_q.protocol <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	pppfs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.payload_byte  (payload_byte),
		.end_of_packet (end_of_packet),
		.q_full        (q_full),
		.q_wr          (q_wr),
		.q_item        (wr_item)
	);

	pppfs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (wr_item),
		.full    (q_full),
		.rd      (q_rd),
		.valid   (q_valid),
		.rd_item (rd_item)
	);

	pppfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (rd_item),
		.q_rd         (q_rd),
		.empty        (empty),
		.pop          (pop),
		.line_byte    (line_byte),
		.last_of_run  (last_of_run),
		.frame_closed (frame_closed)
	);

endmodule

// File: test/ppp_frame_stuffer_crc16_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppp_frame_stuffer_crc16_checker: line stream scoreboard for the PPP framer
// Watches the request, line and register channels of the framer, predicts the
// header, stuffed bytes, FCS and closing flag of every accepted request, and
// compares each popped line byte field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ppp_frame_stuffer_crc16_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] payload_byte,
	input  logic       end_of_packet,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] line_byte,
	input  logic       last_of_run,
	input  logic       frame_closed,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         mismatch_count,
	output int         bytes_owed
);

	typedef struct packed {
		logic [7:0] line;
		logic       last;
		logic       closed;
	} line_beat_t;

	line_beat_t  owed_beats[$];
	logic [7:0]  hdr_address;
	logic [7:0]  hdr_control;
	logic [7:0]  hdr_protocol;
	logic        frame_open;
	logic [15:0] fcs;

	function automatic logic [15:0] fcs16_feed(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		int          k;
		c = acc ^ {8'h00, b};
		for (k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ pppfs_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	task automatic frame_payload_byte(input logic [7:0] b, input logic eop);
		logic [7:0] covered[$];
		line_beat_t beats[$];
		int         i;
		if (!frame_open) begin
			fcs = pppfs_pkg::CRC_INIT;
			covered.push_back(pppfs_pkg::FLAG_BYTE);
			covered.push_back(hdr_address);
			covered.push_back(hdr_control);
			covered.push_back(pppfs_pkg::PAD_BYTE);
			covered.push_back(hdr_protocol);
			frame_open = 1'b1;
		end
		if (b == pppfs_pkg::FLAG_BYTE || b == pppfs_pkg::ESC_BYTE ||
			b < pppfs_pkg::CTRL_LIMIT) begin
			covered.push_back(pppfs_pkg::ESC_BYTE);
			covered.push_back(b ^ pppfs_pkg::ESC_XOR);
		end else begin
			covered.push_back(b);
		end
		for (i = 0; i < covered.size(); i++) begin
			fcs = fcs16_feed(fcs, covered[i]);
			beats.push_back('{covered[i], 1'b0, 1'b0});
		end
		if (eop) begin
			beats.push_back('{fcs[7:0], 1'b0, 1'b0});
			beats.push_back('{fcs[15:8], 1'b0, 1'b0});
			beats.push_back('{pppfs_pkg::FLAG_BYTE, 1'b0, 1'b1});
			frame_open = 1'b0;
			fcs = pppfs_pkg::CRC_INIT;
		end
		beats[beats.size() - 1].last = 1'b1;
		for (i = 0; i < beats.size(); i++) begin
			owed_beats.push_back(beats[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_beat_t want;
		int         bad;
		bad = 0;
		if (!arst_n) begin
			owed_beats.delete();
			hdr_address = pppfs_pkg::ADDR_RESET;
			hdr_control = pppfs_pkg::CTRL_RESET;
			hdr_protocol = pppfs_pkg::PROTO_RESET;
			frame_open = 1'b0;
			fcs = pppfs_pkg::CRC_INIT;
			bytes_owed <= 0;
		end else begin
			if (pop && !empty) begin
				if (owed_beats.size() == 0) begin
					$error("line_byte 0x%02h popped with no request waiting", line_byte);
					bad++;
				end else begin
					want = owed_beats.pop_front();
					if (line_byte !== want.line) begin
						$error("line_byte: expected 0x%02h, got 0x%02h", want.line, line_byte);
						bad++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
						bad++;
					end
					if (frame_closed !== want.closed) begin
						$error("frame_closed: expected %0b, got %0b", want.closed, frame_closed);
						bad++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					pppfs_pkg::REG_ADDRESS: begin
						hdr_address = cfg_wdata;
					end
					pppfs_pkg::REG_CONTROL: begin
						hdr_control = cfg_wdata;
					end
					pppfs_pkg::REG_PROTOCOL: begin
						hdr_protocol = cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (push && !full) begin
				frame_payload_byte(payload_byte, end_of_packet);
			end
			bytes_owed <= owed_beats.size();
			mismatch_count <= mismatch_count + bad;
		end
	end

endmodule

// File: test/ppp_frame_stuffer_crc16_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppp_frame_stuffer_crc16_test: testbench of the PPP frame stuffer
// Drives payload byte requests through directed frames and random phases under
// several header settings, with random stalls on both sides and one long line
// stall, and leaves all prediction and comparison to the attached checker.
// ----------------------------------------------------------------------------
module ppp_frame_stuffer_crc16_test;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int LONG_HOLD = 120;
	localparam int SETTLE = 16;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 64;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] payload_byte;
	logic       end_of_packet;
	logic       empty;
	logic       pop;
	logic [7:0] line_byte;
	logic       last_of_run;
	logic       frame_closed;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	int mismatch_count;
	int bytes_owed;
	bit idling = 1'b1;
	int hold_requests = 0;

	always #6 clk = ~clk;

	ppp_frame_stuffer_crc16 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.end_of_packet(end_of_packet),
		.empty        (empty),
		.pop          (pop),
		.line_byte    (line_byte),
		.last_of_run  (last_of_run),
		.frame_closed (frame_closed),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	ppp_frame_stuffer_crc16_checker line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.payload_byte  (payload_byte),
		.end_of_packet (end_of_packet),
		.empty         (empty),
		.pop           (pop),
		.line_byte     (line_byte),
		.last_of_run   (last_of_run),
		.frame_closed  (frame_closed),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatch_count(mismatch_count),
		.bytes_owed    (bytes_owed)
	);

	task automatic send_byte(input logic [7:0] b, input logic eop);
		if (idling && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		payload_byte <= b;
		end_of_packet <= eop;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (bytes_owed != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int         holds_done;
		int         gap;
		holds_done = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (idling && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 7);
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	initial begin
		int         phase;
		int         n;
		logic [7:0] b;
		arst_n <= 1'b0;
		push <= 1'b0;
		payload_byte <= 8'h00;
		end_of_packet <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= pppfs_pkg::REG_ADDRESS;
		cfg_wdata <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(pppfs_pkg::ESC_BYTE, 1'b0);
		send_byte(pppfs_pkg::FLAG_BYTE, 1'b0);
		send_byte(8'hFF, 1'b1);
		// A frame of a single flag byte produces the longest run of line bytes.
		send_byte(pppfs_pkg::FLAG_BYTE, 1'b1);
		wait_drained();

		write_reg(pppfs_pkg::REG_ADDRESS, 8'h00);
		write_reg(pppfs_pkg::REG_CONTROL, 8'hFF);
		write_reg(pppfs_pkg::REG_PROTOCOL, pppfs_pkg::FLAG_BYTE);
		write_reg(REG_SPARE, 8'hA5);
		send_byte(8'h80, 1'b0);
		send_byte(8'h5E, 1'b0);
		send_byte(8'h01, 1'b1);

		// A header change while a frame is open must wait for the next header.
		send_byte(8'h41, 1'b0);
		wait_drained();
		write_reg(pppfs_pkg::REG_ADDRESS, pppfs_pkg::ESC_BYTE);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h10, 1'b1);
		wait_drained();

		write_reg(pppfs_pkg::REG_ADDRESS, 8'hFF);
		write_reg(pppfs_pkg::REG_CONTROL, 8'h00);
		write_reg(pppfs_pkg::REG_PROTOCOL, 8'h00);

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 1) begin
				hold_requests <= hold_requests + 1;
			end
			if (phase == PHASES - 1) begin
				idling <= 1'b0;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 7))
					0: begin
						b = pppfs_pkg::FLAG_BYTE;
					end
					1: begin
						b = pppfs_pkg::ESC_BYTE;
					end
					2: begin
						b = 8'($urandom_range(0, 31));
					end
					default: begin
						b = 8'($urandom);
					end
				endcase
				send_byte(b, $urandom_range(0, 5) == 0);
			end
			wait_drained();
			if (phase == 0) begin
				write_reg(pppfs_pkg::REG_ADDRESS, 8'hFF);
				write_reg(pppfs_pkg::REG_CONTROL, 8'hFF);
				write_reg(pppfs_pkg::REG_PROTOCOL, 8'hFF);
			end else begin
				write_reg(pppfs_pkg::REG_ADDRESS, 8'($urandom));
				write_reg(pppfs_pkg::REG_CONTROL, 8'($urandom));
				write_reg(pppfs_pkg::REG_PROTOCOL, 8'($urandom));
			end
		end

		wait_drained();
		if (mismatch_count == 0) begin
			$display("ppp_frame_stuffer_crc16_test: done, clean");
		end else begin
			$display("ppp_frame_stuffer_crc16_test: done, errors");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("ppp_frame_stuffer_crc16_test: done, errors");
		$finish;
	end

endmodule
